// File: rtl/tbdg_pkg.sv
// Shared types and constants for the two-button debounce and gesture block.
// Used by tbdg_btn and two_button_debounce_gesture; depends on nothing.
`default_nettype none

package tbdg_pkg;

	localparam int TIME_W = 32;
	localparam int MS_W   = 16;

	typedef logic [TIME_W-1:0] time_ms_t;
	typedef logic [MS_W-1:0]   ms16_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_DEBOUNCE_TIME = 1'b0,
		CFG_CLICK_MAX_MS  = 1'b1
	} cfg_idx_t;

	localparam ms16_t DEBOUNCE_RST  = 16'd50;
	localparam ms16_t CLICK_MAX_RST = 16'd2000;

	// Per-button command for one transaction.
	typedef struct packed {
		logic  en;     // the transaction updates state this cycle
		logic  start;  // start request instead of a tick
		logic  raw;    // raw level, 1 means pressed
		logic  fire;   // the hold query fired on this button
		ms16_t hms;    // hold threshold of the query
	} btn_ctl_t;

	// Per-button status after this transaction's tick or start update.
	typedef struct packed {
		logic     pressed_new;
		logic     press_evt;
		logic     release_evt;
		time_ms_t held;      // time since the press, zero on a fresh press
		ms16_t    rep_new;   // reported hold threshold
	} btn_sts_t;

endpackage

`default_nettype wire

// File: rtl/tbdg_btn.sv
// Debounce state and press timing of a single button.
// Depends on tbdg_pkg for the command and status structs.
`default_nettype none

module tbdg_btn (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire tbdg_pkg::btn_ctl_t ctl,
	input  wire tbdg_pkg::time_ms_t now_new,
	input  wire tbdg_pkg::ms16_t    settle_ticks,
	output tbdg_pkg::btn_sts_t      sts
);
	import tbdg_pkg::*;

	logic     last_q;
	time_ms_t change_q;
	logic     pressed_q;
	time_ms_t press_q;
	ms16_t    rep_q;

	logic changed;
	logic stable;

	always_comb begin
		changed = ctl.raw != last_q;
		// A fresh level change is stable at once only with a zero debounce time.
		if (changed) begin
			stable = settle_ticks == '0;
		end else begin
			stable = (now_new - change_q) >= {{(TIME_W-MS_W){1'b0}}, settle_ticks};
		end
		sts.press_evt   = !ctl.start && stable && ctl.raw && !pressed_q;
		sts.release_evt = !ctl.start && stable && !ctl.raw && pressed_q;
		if (ctl.start) begin
			sts.pressed_new = ctl.raw;
		end else begin
			sts.pressed_new = sts.press_evt | (pressed_q & ~sts.release_evt);
		end
		sts.held    = sts.press_evt ? '0 : (now_new - press_q);
		sts.rep_new = sts.press_evt ? '0 : rep_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			change_q  <= '0;
			pressed_q <= 1'b0;
			press_q   <= '0;
			rep_q     <= '0;
		end else if (ctl.en) begin
			last_q    <= ctl.raw;
			pressed_q <= sts.pressed_new;
			if (!ctl.start && changed) begin
				change_q <= now_new;
			end
			if (sts.press_evt) begin
				press_q <= now_new;
			end
			rep_q <= ctl.fire ? ctl.hms : sts.rep_new;
		end
	end

endmodule

`default_nettype wire

// File: rtl/two_button_debounce_gesture.sv
// Top level of the two-button debounce and gesture block.
// Depends on tbdg_pkg and instantiates tbdg_btn once for each button.
`default_nettype none

// Each input transaction is a 1 ms tick carrying the raw levels of two buttons
// (button one active high, button two active low) or a start request that
// samples the initial levels and arms a power-on lockout when button one is
// held. Every input transaction yields exactly one result transaction with the
// debounced states, the click flags as they stand before this transaction's
// acknowledge bits clear them, the one-shot hold answer and the lockout state.
// An input transaction is captured in an input register; when the output register
// is free, the state of both buttons is updated and the result is written to the
// output register. One transaction is taken every cycle as long as the result side
// keeps up. A stalled output register holds its result; the input register then
// keeps one more transaction and the input stalls. The millisecond counter keeps
// its successor in a register so that one subtract and compare per button sits in
// the update path. Configuration is written through cfg_we, cfg_idx and cfg_wdata;
// the user must do so only while idle, which the block itself does not enforce.

module two_button_debounce_gesture (
	input  wire                      clk,
	input  wire                      arst_n,
	// configuration
	input  wire                      cfg_we,
	input  wire tbdg_pkg::cfg_idx_t  cfg_idx,
	input  wire tbdg_pkg::ms16_t     cfg_wdata,
	// input channel
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire                      start_req,
	input  wire                      level_btn1,
	input  wire                      level_btn2,
	input  wire                      ack_click1,
	input  wire                      ack_click2,
	input  wire                      hold_ask,
	input  wire                      hold_button,
	input  wire tbdg_pkg::ms16_t     hold_ms,
	// output channel
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic                     pressed1,
	output logic                     pressed2,
	output logic                     any_pressed,
	output logic                     click1,
	output logic                     click2,
	output logic                     hold_hit,
	output logic                     lockout
);
	import tbdg_pkg::*;

	// Configuration registers.
	ms16_t debounce_q;
	ms16_t click_max_q;

	// Input register stage.
	logic  valid_s1;
	logic  start_s1;
	logic  lvl1_s1;
	logic  lvl2_s1;
	logic  ack1_s1;
	logic  ack2_s1;
	logic  ask_s1;
	logic  sel_s1;
	ms16_t hms_s1;

	// Shared state.
	time_ms_t now_q;
	time_ms_t nxt_q;
	logic     lock_q;
	logic     click0_q;
	logic     click1_q;

	logic     adv;
	logic     in_acc;
	time_ms_t now_new;
	btn_ctl_t ctl0, ctl1;
	btn_sts_t sts0, sts1;
	logic     lock_new;
	logic     click0_new;
	logic     click1_new;
	logic     hit;
	logic     sel_pressed;
	time_ms_t sel_held;
	ms16_t    sel_rep;

	// The input register hands over when the output register is empty or is
	// being drained in this cycle.
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign now_new  = start_s1 ? now_q : nxt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			click_max_q <= CLICK_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DEBOUNCE_TIME: debounce_q  <= cfg_wdata;
				CFG_CLICK_MAX_MS:  click_max_q <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_s1 <= start_req;
			lvl1_s1  <= level_btn1;
			lvl2_s1  <= level_btn2;
			ack1_s1  <= ack_click1;
			ack2_s1  <= ack_click2;
			ask_s1   <= hold_ask;
			sel_s1   <= hold_button;
			hms_s1   <= hold_ms;
		end
	end

	// Hold query on the chosen button, after this transaction's update.
	always_comb begin
		sel_pressed = sel_s1 ? sts1.pressed_new : sts0.pressed_new;
		sel_held    = sel_s1 ? sts1.held : sts0.held;
		sel_rep     = sel_s1 ? sts1.rep_new : sts0.rep_new;
		hit = ask_s1 && sel_pressed && !(!sel_s1 && lock_new)
			&& (sel_held >= {{(TIME_W-MS_W){1'b0}}, hms_s1})
			&& (sel_rep < hms_s1);
	end

	always_comb begin
		ctl0.en    = adv;
		ctl0.start = start_s1;
		ctl0.raw   = lvl1_s1;
		ctl0.fire  = hit && !sel_s1;
		ctl0.hms   = hms_s1;
		ctl1.en    = adv;
		ctl1.start = start_s1;
		ctl1.raw   = ~lvl2_s1;
		ctl1.fire  = hit && sel_s1;
		ctl1.hms   = hms_s1;
	end

	tbdg_btn u_btn0 (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl0),
		.now_new      (now_new),
		.settle_ticks (debounce_q),
		.sts          (sts0)
	);

	tbdg_btn u_btn1 (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl1),
		.now_new      (now_new),
		.settle_ticks (debounce_q),
		.sts          (sts1)
	);

	// The first release of button one under lockout only lifts the lockout;
	// any later release is a click when the press was short enough.
	always_comb begin
		if (start_s1) begin
			lock_new = lvl1_s1;
		end else if (sts0.release_evt) begin
			lock_new = 1'b0;
		end else begin
			lock_new = lock_q;
		end
		click0_new = click0_q || (sts0.release_evt && !lock_q
			&& (sts0.held < {{(TIME_W-MS_W){1'b0}}, click_max_q}));
		click1_new = click1_q || sts1.press_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			nxt_q    <= time_ms_t'(1);
			lock_q   <= 1'b0;
			click0_q <= 1'b0;
			click1_q <= 1'b0;
		end else if (adv) begin
			if (!start_s1) begin
				now_q <= nxt_q;
				nxt_q <= nxt_q + time_ms_t'(1);
			end
			lock_q   <= lock_new;
			click0_q <= click0_new && !ack1_s1;
			click1_q <= click1_new && !ack2_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pressed1    <= sts0.pressed_new;
			pressed2    <= sts1.pressed_new;
			any_pressed <= sts0.pressed_new | sts1.pressed_new;
			click1      <= click0_new;
			click2      <= click1_new;
			hold_hit    <= hit;
			lockout     <= lock_new;
		end
	end

	// The input side stalls only while a transaction waits in the input register.
	a_stall_needs_item : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// The lockout is only ever armed with button one pressed and ends with its release.
	a_lock_pressed : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && lockout) |-> pressed1)
		else $error("lockout active while button one is released");

	// A hold answer on a transaction that moves shows up as hold_hit in the output register.
	a_hit_asked : assert property (@(posedge clk) disable iff (!arst_n)
		(hit && adv) |=> (out_valid && hold_hit))
		else $error("hold hit lost on the way to the output register");

	a_any_pressed : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (any_pressed == (pressed1 || pressed2)))
		else $error("any_pressed disagrees with the button states");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the two-button debounce and gesture block.
// Depends on tbdg_pkg and two_button_debounce_gesture, and through it on tbdg_btn.
// Expected results come from a cycle-free model of the block kept in this file.

module testbench;

	import tbdg_pkg::*;

	// One input transaction, laid out field by field as on the ports.
	typedef struct packed {
		logic  start_req;
		logic  level_btn1;
		logic  level_btn2;
		logic  ack_click1;
		logic  ack_click2;
		logic  hold_ask;
		logic  hold_button;
		ms16_t hold_ms;
	} stim_t;

	// One result transaction. The first field is the most significant bit.
	typedef struct packed {
		logic pressed1;
		logic pressed2;
		logic any_pressed;
		logic click1;
		logic click2;
		logic hold_hit;
		logic lockout;
	} gesture_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// A row of the directed table: either a register write or one input
	// transaction. A row whose result is obvious carries it typed in.
	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t  idx;
		ms16_t     val;
		stim_t     s;
		logic      typed;
		gesture_t  want;
	} row_t;

	localparam logic H = 1'b1;
	localparam logic L = 1'b0;

	localparam stim_t    NO_STIM = '0;
	localparam gesture_t NO_WANT = '0;

	// After the last result the block is given SETTLE_CYCLES idle cycles to settle
	// completely before a register write or the final verdict.
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 1000000;

	// Directed part. Button one is active high and button two active low, so
	// level_btn2 = H means button two is released. The first row runs on the
	// reset values of the registers; the rest mostly uses a zero debounce time
	// so that every level is taken on the tick where it appears.
	// Columns of s: start, btn1, btn2, ack1, ack2, ask, which button, hold ms.
	localparam int DIR_ROWS = 24;
	localparam row_t DIRECTED [DIR_ROWS] = '{
		// After reset with both buttons released, nothing is set.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, H, L, L, L, L, 16'd0}, H, NO_WANT},
		'{ROW_CFG,  CFG_DEBOUNCE_TIME, 16'd0, NO_STIM, L, NO_WANT},
		'{ROW_CFG,  CFG_CLICK_MAX_MS,  16'd3, NO_STIM, L, NO_WANT},
		// A start with button one held arms the lockout at once.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{H, H, H, L, L, L, L, 16'd0}, H,
			'{H, L, H, L, L, L, H}},
		// Hold queries on button one are blocked while the lockout stands.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, H, L, L, H, L, 16'd1}, L, NO_WANT},
		// The first release clears the lockout and gives no click.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, H, L, L, L, L, 16'd0}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, H, L, L, L, L, 16'd0}, L, NO_WANT},
		// A threshold of zero never fires; the largest one does not fire on this short press.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, H, L, L, H, L, 16'd0}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, H, L, L, H, L, 16'hFFFF}, L, NO_WANT},
		// The same threshold fires once per press.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, H, L, L, H, L, 16'd2}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, H, L, L, H, L, 16'd2}, L, NO_WANT},
		// A press longer than the click limit ends without a click.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, H, L, L, L, L, 16'd0}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, H, L, L, L, L, 16'd0}, L, NO_WANT},
		// A short press is a click, read once through the acknowledge.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, H, L, L, L, L, 16'd0}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, H, H, L, L, L, 16'd0}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, H, H, L, L, L, 16'd0}, L, NO_WANT},
		// Button two clicks on its press.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, L, L, L, L, L, 16'd0}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, L, L, H, H, H, 16'd1}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, L, L, L, H, L, 16'd1}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, L, H, L, H, L, L, 16'd0}, L, NO_WANT},
		// With the longest debounce time no level change is taken.
		'{ROW_CFG,  CFG_DEBOUNCE_TIME, 16'hFFFF, NO_STIM, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{L, H, L, L, L, L, L, 16'd0}, L, NO_WANT},
		// Starts load the levels directly, with and without the lockout.
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{H, L, L, H, H, L, L, 16'd0}, L, NO_WANT},
		'{ROW_ITEM, CFG_DEBOUNCE_TIME, 16'd0, '{H, H, H, L, L, H, L, 16'd5}, L, NO_WANT}
	};

	// Random phases: one register setting each, with the extremes among them.
	localparam int PHASES = 8;
	localparam int PH_DEBOUNCE  [PHASES] = '{50,   0,     1, 3,  65535, 5,  2, 0};
	localparam int PH_CLICK_MAX [PHASES] = '{2000, 0, 65535, 12, 0,     30, 8, 5};
	localparam int PH_ITEMS     [PHASES] = '{300,  200, 200, 300, 100,  300, 300, 100};

	logic     clk        = 1'b0;
	logic     arst_n     = 1'b0;
	logic     cfg_we     = 1'b0;
	cfg_idx_t cfg_idx    = CFG_DEBOUNCE_TIME;
	ms16_t    cfg_wdata  = '0;
	logic     in_valid   = 1'b0;
	logic     start_req  = 1'b0;
	logic     level_btn1 = 1'b0;
	logic     level_btn2 = 1'b1;
	logic     ack_click1 = 1'b0;
	logic     ack_click2 = 1'b0;
	logic     hold_ask   = 1'b0;
	logic     hold_button = 1'b0;
	ms16_t    hold_ms    = '0;
	logic     out_stall  = 1'b0;
	logic     in_stall;
	logic     out_valid;
	logic     pressed1;
	logic     pressed2;
	logic     any_pressed;
	logic     click1;
	logic     click2;
	logic     hold_hit;
	logic     lockout;

	two_button_debounce_gesture u_dut (.*);

	always #5 clk = ~clk;

	// Model state of the block, with the same widths as the hardware.
	ms16_t    debounce_set;
	ms16_t    click_max_set;
	time_ms_t tick_ms;
	logic     raw_seen      [2];
	time_ms_t raw_since     [2];
	logic     held_down     [2];
	time_ms_t down_since    [2];
	logic     click_pend    [2];
	ms16_t    hold_reported [2];
	logic     power_lock;

	gesture_t gesture_q [$];

	int    cycles     = 0;
	int    errors     = 0;
	int    results    = 0;
	int    stall_left = 0;
	logic  calm       = 1'b0;
	logic  aim_down1  = 1'b0;
	logic  aim_down2  = 1'b0;
	int    level_run  = 0;
	string field_name [7] = '{"pressed1", "pressed2", "any_pressed", "click1", "click2",
		"hold_hit", "lockout"};

	// Applies one transaction to the model and returns the result it causes.
	// The order follows the block: tick or start, hold query, result capture,
	// and finally the acknowledge clears.
	function automatic gesture_t predict_gesture(stim_t s);
		logic     raw [2];
		logic     hit;
		gesture_t g;
		int       b;
		raw[0] = s.level_btn1;
		raw[1] = ~s.level_btn2;
		hit = 1'b0;
		if (s.start_req) begin
			// A start loads the levels without debouncing and does not
			// advance the millisecond counter.
			for (b = 0; b < 2; b++) begin
				raw_seen[b] = raw[b];
				held_down[b] = raw[b];
			end
			power_lock = raw[0];
		end else begin
			tick_ms = tick_ms + 1;
			for (b = 0; b < 2; b++) begin
				if (raw[b] != raw_seen[b]) begin
					raw_seen[b] = raw[b];
					raw_since[b] = tick_ms;
				end
				// All time differences wrap at 32 bits.
				if (time_ms_t'(tick_ms - raw_since[b]) >= time_ms_t'(debounce_set)) begin
					if (raw[b] && !held_down[b]) begin
						held_down[b] = 1'b1;
						down_since[b] = tick_ms;
						hold_reported[b] = '0;
						if (b == 1)
							click_pend[1] = 1'b1;
					end else if (!raw[b] && held_down[b]) begin
						held_down[b] = 1'b0;
						if (b == 0) begin
							if (power_lock)
								power_lock = 1'b0;
							else if (time_ms_t'(tick_ms - down_since[0]) <
									time_ms_t'(click_max_set))
								click_pend[0] = 1'b1;
						end
					end
				end
			end
		end
		// A hold query fires once per threshold; button one answers nothing
		// while the power-on lockout stands.
		if (s.hold_ask && held_down[s.hold_button] && !(s.hold_button == 1'b0 && power_lock)
				&& time_ms_t'(tick_ms - down_since[s.hold_button]) >= time_ms_t'(s.hold_ms)
				&& hold_reported[s.hold_button] < s.hold_ms) begin
			hold_reported[s.hold_button] = s.hold_ms;
			hit = 1'b1;
		end
		g.pressed1 = held_down[0];
		g.pressed2 = held_down[1];
		g.any_pressed = held_down[0] | held_down[1];
		g.click1 = click_pend[0];
		g.click2 = click_pend[1];
		g.hold_hit = hit;
		g.lockout = power_lock;
		if (s.ack_click1)
			click_pend[0] = 1'b0;
		if (s.ack_click2)
			click_pend[1] = 1'b0;
		return g;
	endfunction

	// Idle lengths: mostly none or short, now and then a long one. During a
	// calm stretch neither side idles at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Builds the next random tick or start. The button levels follow held
	// targets that change after runs sized by the debounce time, so that most
	// presses and releases get through the debouncer. Short runs and single
	// flipped ticks act as contact bounce.
	function automatic stim_t next_button_stim();
		stim_t s;
		int    dcap;
		int    ccap;
		int    r;
		dcap = (debounce_set > 200) ? 200 : int'(debounce_set);
		ccap = (click_max_set > 400) ? 400 : int'(click_max_set);
		s = '0;
		if (level_run == 0) begin
			case ($urandom_range(0, 2))
				0: aim_down1 = ~aim_down1;
				1: aim_down2 = ~aim_down2;
				default: begin
					aim_down1 = ~aim_down1;
					aim_down2 = ~aim_down2;
				end
			endcase
			r = $urandom_range(0, 99);
			if (r < 15)
				level_run = $urandom_range(1, dcap + 1);
			else if (r < 22)
				level_run = dcap + $urandom_range(1, ccap + 20);
			else
				level_run = dcap + $urandom_range(1, 4 * dcap + 8);
		end
		level_run--;
		s.start_req = ($urandom_range(0, 99) < 2);
		s.level_btn1 = aim_down1 ^ ($urandom_range(0, 99) < 4);
		s.level_btn2 = ~aim_down2 ^ ($urandom_range(0, 99) < 4);
		s.ack_click1 = ($urandom_range(0, 99) < 30);
		s.ack_click2 = ($urandom_range(0, 99) < 30);
		s.hold_ask = ($urandom_range(0, 99) < 35);
		s.hold_button = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 10)
			s.hold_ms = ms16_t'($urandom());
		else if (r < 14)
			s.hold_ms = '0;
		else if (r < 17)
			s.hold_ms = '1;
		else
			s.hold_ms = ms16_t'($urandom_range(1, 4 * dcap + 20));
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Offers one transaction, starting and ending on a falling edge. The
	// expected result is recorded at the rising edge that accepts it.
	task automatic send_item(stim_t s, logic typed, gesture_t want);
		int       gap;
		gesture_t g;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_req <= s.start_req;
		level_btn1 <= s.level_btn1;
		level_btn2 <= s.level_btn2;
		ack_click1 <= s.ack_click1;
		ack_click2 <= s.ack_click2;
		hold_ask <= s.hold_ask;
		hold_button <= s.hold_button;
		hold_ms <= s.hold_ms;
		do
			@(posedge clk);
		while (in_stall);
		// The model always runs so that its state tracks the block, even
		// where the table supplies the expected result itself.
		g = predict_gesture(s);
		gesture_q.push_back(typed ? want : g);
		@(negedge clk);
	endtask

	// Holds the input back until every outstanding result has arrived and
	// the pipeline has had time to empty.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (gesture_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes one register while the block is idle and mirrors it in the model.
	task automatic write_reg(cfg_idx_t idx, ms16_t val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == CFG_DEBOUNCE_TIME)
			debounce_set = val;
		else
			click_max_set = val;
	endtask

	// The result side stalls at random, with the same mix of short and long
	// stretches as the sender's gaps.
	always @(negedge clk) begin
		if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every accepted result is compared field by field with the oldest
	// expectation.
	always @(posedge clk) begin
		gesture_t got;
		gesture_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {pressed1, pressed2, any_pressed, click1, click2, hold_hit, lockout};
			if (gesture_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected", results));
			end else begin
				want = gesture_q.pop_front();
				for (int i = 6; i >= 0; i--) begin
					if (got[i] !== want[i])
						report_mismatch($sformatf("result %0d field %s got %b expected %b",
							results, field_name[6 - i], got[i], want[i]));
				end
			end
			results++;
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		debounce_set = DEBOUNCE_RST;
		click_max_set = CLICK_MAX_RST;
		tick_ms = '0;
		power_lock = 1'b0;
		for (int b = 0; b < 2; b++) begin
			raw_seen[b] = 1'b0;
			raw_since[b] = '0;
			held_down[b] = 1'b0;
			down_since[b] = '0;
			click_pend[b] = 1'b0;
			hold_reported[b] = '0;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				wait_all_results();
				write_reg(DIRECTED[i].idx, DIRECTED[i].val);
			end else begin
				send_item(DIRECTED[i].s, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_all_results();
			write_reg(CFG_DEBOUNCE_TIME, ms16_t'(PH_DEBOUNCE[p]));
			write_reg(CFG_CLICK_MAX_MS, ms16_t'(PH_CLICK_MAX[p]));
			for (int n = 0; n < PH_ITEMS[p]; n++) begin
				// About one stretch in four runs with no idling on either side.
				if (n % 64 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// Now and then the sender waits for the pipeline to drain.
				if ($urandom_range(0, 299) == 0)
					wait_all_results();
				send_item(next_button_stim(), 1'b0, NO_WANT);
			end
		end

		calm = 1'b0;
		wait_all_results();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/tbdg_pkg.sv
rtl/tbdg_btn.sv
rtl/two_button_debounce_gesture.sv
bench/testbench.sv
